FILE: rtl/core/afls_pkg.sv
// Package of the AX.25 KISS frame learning switch: constants, codes, state
// encoding and the callsign compare function. No dependencies.
`default_nettype none

package afls_pkg;

  localparam int NUM_CHANNELS_DEF = 9;
  localparam int FRAME_BYTES_DEF  = 4096;
  localparam int MAX_ADDRS_DEF    = 10;
  localparam int ADDR_BYTES       = 7;

  localparam int CH_W   = 4;
  localparam int LEN_W  = 13;
  localparam int FWD_W  = 9;
  localparam int STAT_W = 2;
  localparam int CALL_W = 8 * ADDR_BYTES;

  localparam logic [7:0] FEND_BYTE      = 8'o300;
  localparam logic [7:0] KISS_TYPE_MASK = 8'h0f;
  localparam logic [7:0] EXT_BIT        = 8'h01;
  localparam logic [7:0] REPEAT_BIT     = 8'h80;
  localparam logic [7:0] SSID_BITS      = 8'h1e;

  // Byte k of a call sits at bits [8k +: 8].
  localparam logic [CALL_W-1:0] QST_CALL   = 56'h61_40_40_40_A8_A6_A2;
  localparam logic [CALL_W-1:0] NODES_CALL = 56'h61_40_A6_8A_88_9E_9C;

  typedef enum logic [STAT_W-1:0] {
    ST_ROUTED   = 2'd0,
    ST_NOT_DATA = 2'd1,
    ST_BAD_HDR  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    REG_ALL_MULTICAST   = 1'b0,
    REG_CHANNELS_IN_USE = 1'b1
  } reg_idx_t;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_RT   = 9'b000000010,
    S_CT   = 9'b000000100,
    S_RE   = 9'b000001000,
    S_CE   = 9'b000010000,
    S_LD   = 9'b000100000,
    S_LRN  = 9'b001000000,
    S_CMP  = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  function automatic logic call_match(input logic [CALL_W-1:0] x,
                                      input logic [CALL_W-1:0] y);
    logic [7:0] d;
    d = (x[CALL_W-1 -: 8] ^ y[CALL_W-1 -: 8]) & SSID_BITS;
    return (x[CALL_W-9:0] == y[CALL_W-9:0]) && (d == 8'h00);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/afls_match_unit.sv
// Shared channel compare unit: decides whether one channel gets the frame.
// Depends on afls_pkg for the call width and the compare function.
`default_nettype none

module afls_match_unit (
  input  wire logic [afls_pkg::CALL_W-1:0] dest_call,
  input  wire logic [afls_pkg::CALL_W-1:0] chan_call,
  input  wire logic                        multi,
  output logic                             hit
);
  import afls_pkg::*;

  // An unlearned channel (first byte zero) always gets the frame.
  assign hit = multi || (chan_call[7:0] == 8'h00) || call_match(dest_call, chan_call);

endmodule

`default_nettype wire

FILE: rtl/core/ax25_frame_learning_switch.sv
// Top level of the AX.25 KISS frame learning switch: per-channel byte
// counting, header memory, address walk sequencer and forward decision.
// Depends on afls_pkg and afls_match_unit.
`default_nettype none

// Every input item is one received byte with its channel number. A byte on
// a channel at or above channels_in_use (clipped to NUM_CHANNELS) is dropped.
// Ordinary bytes are counted and the first 1+7*MAX_ADDRS of each frame land in
// a header memory with one write and one read port (one row per channel). A
// 0xC0 byte ends the frame; a frame of two or more bytes yields one result
// item. The end byte starts a sequencer that reads the header memory byte by
// byte: the KISS type byte, then the last byte of each address while walking
// the chain, then the 14 bytes of the learned call and of the next hop, and
// then runs one shared compare unit over the active channels, one channel per
// cycle. The walk reads at least the source address. An overflowed frame goes
// to the output state without reads, a non-data or too-short frame stops after
// the type byte, and a frame whose walk fails stops after its last address
// read. The block is not ready while the sequencer runs. The result sits in
// an output register, so the next byte is taken while a result still waits;
// a second result waits in the final state until the first is taken. The
// header memory needs no clearing: only bytes written in the current frame
// are ever read.
module ax25_frame_learning_switch #(
  parameter int NUM_CHANNELS = afls_pkg::NUM_CHANNELS_DEF,
  parameter int FRAME_BYTES  = afls_pkg::FRAME_BYTES_DEF,
  parameter int MAX_ADDRS    = afls_pkg::MAX_ADDRS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [afls_pkg::CH_W-1:0]   in_channel,
  input  wire logic [7:0]                  in_data_byte,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [afls_pkg::CH_W-1:0]        out_source_channel,
  output logic [afls_pkg::LEN_W-1:0]       out_frame_length,
  output logic [afls_pkg::FWD_W-1:0]       out_forward_mask,
  output logic [afls_pkg::STAT_W-1:0]      out_status,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [2:0]                  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import afls_pkg::*;

  localparam int HDR_BYTES = 1 + MAX_ADDRS * ADDR_BYTES;
  localparam int DEPTH     = NUM_CHANNELS * HDR_BYTES;
  localparam int AW        = $clog2(DEPTH);
  localparam int HOFF_W    = $clog2(HDR_BYTES + 1);
  localparam int CNT_W     = $clog2(FRAME_BYTES + 2);
  localparam int CIDX_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int N_W       = $clog2(MAX_ADDRS + 1);
  localparam int USED_W    = CH_W + 1;
  localparam int J_W       = $clog2(2 * ADDR_BYTES + 1);

  // ---------------- configuration registers ----------------
  logic              all_mc_r;
  logic [CH_W-1:0]   ch_in_use_r;
  logic              cfg_wr;
  reg_idx_t          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      all_mc_r    <= 1'b0;
      ch_in_use_r <= CH_W'(2);
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ALL_MULTICAST:   all_mc_r    <= pwdata[0];
        REG_CHANNELS_IN_USE: ch_in_use_r <= pwdata[CH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ALL_MULTICAST:   prdata = {31'd0, all_mc_r};
      REG_CHANNELS_IN_USE: prdata = {{(32-CH_W){1'b0}}, ch_in_use_r};
      default:             prdata = 32'd0;
    endcase
  end

  // Active channel count clipped to the build size.
  logic [USED_W-1:0] used;
  assign used = (USED_W'(ch_in_use_r) > USED_W'(NUM_CHANNELS)) ?
                USED_W'(NUM_CHANNELS) : USED_W'(ch_in_use_r);

  // ---------------- state ----------------
  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         byte_count_r [NUM_CHANNELS];
  logic [CALL_W-1:0]        learned_r    [NUM_CHANNELS];
  logic [7:0]               hdr_mem      [DEPTH];
  logic [7:0]               rd_data_r;

  logic [CH_W-1:0]          ch_r,     ch_nxt;
  logic [USED_W-1:0]        used_r,   used_nxt;
  logic [AW-1:0]            base_r,   base_nxt;
  logic [CNT_W-1:0]         cnt_r,    cnt_nxt;
  logic [HOFF_W-1:0]        ap_r,     ap_nxt;
  logic [HOFF_W-1:0]        src_r,    src_nxt;
  logic [HOFF_W-1:0]        dest_r,   dest_nxt;
  logic [N_W-1:0]           n_r,      n_nxt;
  logic                     first_r,  first_nxt;
  logic [J_W-1:0]           j_r,      j_nxt;
  logic [2*CALL_W-1:0]      calls_r,  calls_nxt;
  logic                     multi_r,  multi_nxt;
  logic [USED_W-1:0]        i_r,      i_nxt;
  logic [FWD_W-1:0]         mask_r,   mask_nxt;
  status_t                  stat_r,   stat_nxt;

  logic                     out_valid_r;
  logic [CH_W-1:0]          out_ch_r;
  logic [LEN_W-1:0]         out_len_r;
  logic [FWD_W-1:0]         out_mask_r;
  status_t                  out_stat_r;

  logic                     in_acc;
  logic                     in_active;
  logic [CIDX_W-1:0]        in_idx;
  logic [CNT_W-1:0]         cnt_cur, cnt_inc;
  logic                     hdr_wr;
  logic [AW-1:0]            in_base;
  logic [AW-1:0]            rd_addr;
  logic [HOFF_W-1:0]        rd_off;
  logic                     out_load;
  logic                     learn_wr;
  logic                     hit;
  logic [CALL_W-1:0]        src_call, dest_call;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign in_active = USED_W'(in_channel) < used;
  assign in_idx    = in_channel[CIDX_W-1:0];
  assign cnt_cur   = byte_count_r[in_idx];
  assign cnt_inc   = (cnt_cur <= CNT_W'(FRAME_BYTES)) ? cnt_cur + CNT_W'(1) : cnt_cur;
  assign hdr_wr    = in_acc && in_active && (cnt_cur < CNT_W'(HDR_BYTES));
  assign in_base   = AW'(in_channel) * AW'(HDR_BYTES);
  assign rd_addr   = base_r + AW'(rd_off);
  assign src_call  = calls_r[CALL_W-1:0];
  assign dest_call = calls_r[2*CALL_W-1:CALL_W];
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_ready);
  assign learn_wr  = (state_r == S_LRN);

  // Header memory: one write port for arriving bytes, one registered read port.
  always_ff @(posedge clk) begin
    if (hdr_wr) begin
      hdr_mem[in_base + AW'(cnt_cur[HOFF_W-1:0])] <= in_data_byte;
    end
    rd_data_r <= hdr_mem[rd_addr];
  end

  // Per-channel byte counters and learned calls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        byte_count_r[c] <= '0;
        learned_r[c]    <= '0;
      end
    end else begin
      if (in_acc && in_active) begin
        byte_count_r[in_idx] <= (in_data_byte == FEND_BYTE) ? '0 : cnt_inc;
      end
      if (learn_wr) begin
        learned_r[ch_r[CIDX_W-1:0]] <= src_call;
      end
    end
  end

  afls_match_unit u_match (
    .dest_call (dest_call),
    .chan_call (learned_r[i_r[CIDX_W-1:0]]),
    .multi     (multi_r),
    .hit       (hit)
  );

  // Read offset chosen by the sequencer.
  always_comb begin
    case (state_r)
      S_RE:    rd_off = ap_r + HOFF_W'(ADDR_BYTES - 1);
      S_LD:    rd_off = (j_r < J_W'(ADDR_BYTES)) ? src_r + HOFF_W'(j_r)
                                                 : dest_r + HOFF_W'(j_r - J_W'(ADDR_BYTES));
      default: rd_off = '0;
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    used_nxt  = used_r;
    base_nxt  = base_r;
    cnt_nxt   = cnt_r;
    ap_nxt    = ap_r;
    src_nxt   = src_r;
    dest_nxt  = dest_r;
    n_nxt     = n_r;
    first_nxt = first_r;
    j_nxt     = j_r;
    calls_nxt = calls_r;
    multi_nxt = multi_r;
    i_nxt     = i_r;
    mask_nxt  = mask_r;
    stat_nxt  = stat_r;
    case (state_r)
      S_IDLE: begin
        // Start a walk only on a frame end with at least one byte before it.
        if (in_acc && in_active && (in_data_byte == FEND_BYTE) && (cnt_inc > CNT_W'(1))) begin
          ch_nxt   = in_channel;
          used_nxt = used;
          base_nxt = in_base;
          cnt_nxt  = cnt_inc;
          mask_nxt = '0;
          if (cnt_inc > CNT_W'(FRAME_BYTES)) begin
            stat_nxt  = ST_OVERFLOW;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_RT;
          end
        end
      end
      S_RT: state_nxt = S_CT;
      S_CT: begin
        if ((rd_data_r & KISS_TYPE_MASK) != 8'h00) begin
          stat_nxt  = ST_NOT_DATA;
          state_nxt = S_OUT;
        end else if (cnt_r < CNT_W'(2 * ADDR_BYTES + 2)) begin
          stat_nxt  = ST_BAD_HDR;
          state_nxt = S_OUT;
        end else begin
          ap_nxt    = HOFF_W'(1 + ADDR_BYTES);
          src_nxt   = HOFF_W'(1 + ADDR_BYTES);
          dest_nxt  = HOFF_W'(1);
          n_nxt     = N_W'(2);
          first_nxt = 1'b1;
          state_nxt = S_RE;
        end
      end
      S_RE: state_nxt = S_CE;
      S_CE: begin
        first_nxt = 1'b0;
        if (!first_r && ((rd_data_r & REPEAT_BIT) == 8'h00)) begin
          // Unrepeated hop: it is the next destination.
          dest_nxt  = ap_r;
          j_nxt     = '0;
          state_nxt = S_LD;
        end else begin
          if (!first_r) src_nxt = ap_r;
          if ((rd_data_r & EXT_BIT) != 8'h00) begin
            j_nxt     = '0;
            state_nxt = S_LD;
          end else if (n_r >= N_W'(MAX_ADDRS)) begin
            stat_nxt  = ST_BAD_HDR;
            state_nxt = S_OUT;
          end else if (CNT_W'(ap_r) + CNT_W'(2 * ADDR_BYTES) >= cnt_r) begin
            stat_nxt  = ST_BAD_HDR;
            state_nxt = S_OUT;
          end else begin
            ap_nxt    = ap_r + HOFF_W'(ADDR_BYTES);
            n_nxt     = n_r + N_W'(1);
            state_nxt = S_RE;
          end
        end
      end
      S_LD: begin
        // Shift in the byte read on the previous cycle.
        if (j_r != '0) begin
          calls_nxt = {rd_data_r, calls_r[2*CALL_W-1:8]};
        end
        j_nxt = j_r + J_W'(1);
        if (j_r == J_W'(2 * ADDR_BYTES)) begin
          state_nxt = S_LRN;
        end
      end
      S_LRN: begin
        multi_nxt = all_mc_r || call_match(dest_call, QST_CALL) ||
                    call_match(dest_call, NODES_CALL);
        i_nxt     = '0;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (hit) mask_nxt = mask_r | (FWD_W'(1) << i_r);
        i_nxt = i_r + USED_W'(1);
        if (i_r + USED_W'(1) >= used_r) begin
          stat_nxt  = ST_ROUTED;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ch_r    <= ch_nxt;
    used_r  <= used_nxt;
    base_r  <= base_nxt;
    cnt_r   <= cnt_nxt;
    ap_r    <= ap_nxt;
    src_r   <= src_nxt;
    dest_r  <= dest_nxt;
    n_r     <= n_nxt;
    first_r <= first_nxt;
    j_r     <= j_nxt;
    calls_r <= calls_nxt;
    multi_r <= multi_nxt;
    i_r     <= i_nxt;
    mask_r  <= mask_nxt;
    stat_r  <= stat_nxt;
  end

  // Output register: hold the result until taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch_r   <= ch_r;
      out_len_r  <= (cnt_r > CNT_W'(FRAME_BYTES)) ? LEN_W'(FRAME_BYTES) : LEN_W'(cnt_r);
      out_mask_r <= mask_r;
      out_stat_r <= stat_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_source_channel = out_ch_r;
  assign out_frame_length   = out_len_r;
  assign out_forward_mask   = out_mask_r;
  assign out_status         = out_stat_r;

`ifndef SYNTHESIS
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("sequencer state not one-hot");

  a_unrouted_no_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stat_r != ST_ROUTED) |-> (out_mask_r == '0))
    else $error("unrouted frame carries a forward mask");

  a_cmp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> (i_r < used_r))
    else $error("channel compare index past active channels");

  a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result appeared outside the output state");
`endif

endmodule

`default_nettype wire

FILE: tb/tb_ax25_frame_learning_switch.sv
// Self-checking testbench of ax25_frame_learning_switch: KISS frames go in
// byte by byte, and each frame verdict is checked against an in-bench predictor.
// Depends on afls_pkg and the switch RTL.
`default_nettype none

module tb_ax25_frame_learning_switch;
  import afls_pkg::*;

  localparam int NUM_CH    = 9;
  localparam int FRAME_MAX = 4096;
  localparam int ADDR_MAX  = 10;
  localparam int HDR_LEN   = 1 + ADDR_MAX * ADDR_BYTES;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 100;

  // frame shapes produced by the stimulus
  localparam int FK_ROUTED  = 0;
  localparam int FK_TRUNC   = 1;
  localparam int FK_NOEXT   = 2;
  localparam int FK_NOTDATA = 3;
  localparam int FK_NOISE   = 4;

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic [7:0]      data;
  } rx_byte_t;

  typedef struct packed {
    logic [CH_W-1:0]  src;
    logic [LEN_W-1:0] len;
    logic [FWD_W-1:0] mask;
    status_t          st;
  } frame_verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [CH_W-1:0] in_channel = '0;
  logic [7:0] in_data_byte = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [CH_W-1:0] out_source_channel;
  logic [LEN_W-1:0] out_frame_length;
  logic [FWD_W-1:0] out_forward_mask;
  logic [STAT_W-1:0] out_status;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  ax25_frame_learning_switch dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_channel(in_channel), .in_data_byte(in_data_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_source_channel(out_source_channel), .out_frame_length(out_frame_length),
    .out_forward_mask(out_forward_mask), .out_status(out_status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // Predictor state: mirrors the switch's per-channel storage and registers.
  logic [7:0]  hdr_mem [NUM_CH][HDR_LEN];
  int          rx_count [NUM_CH];
  logic [55:0] learned [NUM_CH];
  logic        multicast_all = 1'b0;
  int          active_chans = 2;

  rx_byte_t       pending_bytes [$];
  frame_verdict_t frame_verdicts [$];
  logic [7:0]     frame_buf [$];
  logic [55:0]    call_pool [9];

  int  bytes_queued = 0;
  int  mismatches = 0;
  int  cycles = 0;
  bit  quiet = 1'b0;
  bit  in_taken = 1'b0;
  int  send_gap = 0;
  int  hold_gap = 0;

  function automatic bit same_call(input logic [55:0] x, input logic [55:0] y);
    return (x[47:0] == y[47:0]) && (((x[55:48] ^ y[55:48]) & SSID_BITS) == 8'h00);
  endfunction

  function automatic logic [55:0] call_at(input int ch, input int pos);
    logic [55:0] c;
    for (int k = 0; k < ADDR_BYTES; k++) c[8*k +: 8] = hdr_mem[ch][pos + k];
    return c;
  endfunction

  // Take one received byte; on a frame end push the verdict the switch owes.
  function automatic void route_byte(input int ch, input logic [7:0] b);
    int used, cnt, data_len, dst, src, ap, n;
    bit ok, done, multi;
    logic [55:0] dcall;
    frame_verdict_t v;
    used = (active_chans > NUM_CH) ? NUM_CH : active_chans;
    if (ch >= used) return;
    cnt = rx_count[ch];
    if (cnt < HDR_LEN) hdr_mem[ch][cnt] = b;
    if (cnt <= FRAME_MAX) cnt++;
    rx_count[ch] = (b == FEND_BYTE) ? 0 : cnt;
    if (b != FEND_BYTE || cnt <= 1) return;
    v.src = CH_W'(ch);
    v.len = LEN_W'((cnt > FRAME_MAX) ? FRAME_MAX : cnt);
    v.mask = '0;
    if (cnt > FRAME_MAX) begin
      v.st = ST_OVERFLOW;
    end else if ((hdr_mem[ch][0] & KISS_TYPE_MASK) != 0) begin
      v.st = ST_NOT_DATA;
    end else begin
      // walk the address chain up to the next unrepeated hop
      data_len = cnt - 1;
      dst = 1;
      src = 1 + ADDR_BYTES;
      ap = src;
      n = 2;
      ok = (src + ADDR_BYTES - 1) < data_len;
      done = 1'b0;
      while (ok && !done && !(hdr_mem[ch][ap + ADDR_BYTES - 1] & EXT_BIT)) begin
        if (n >= ADDR_MAX) begin
          ok = 1'b0;
        end else begin
          ap += ADDR_BYTES;
          n++;
          if (ap + ADDR_BYTES - 1 >= data_len) ok = 1'b0;
          else if (hdr_mem[ch][ap + ADDR_BYTES - 1] & REPEAT_BIT) src = ap;
          else begin
            dst = ap;
            done = 1'b1;
          end
        end
      end
      if (!ok) begin
        v.st = ST_BAD_HDR;
      end else begin
        v.st = ST_ROUTED;
        learned[ch] = call_at(ch, src);
        dcall = call_at(ch, dst);
        multi = multicast_all || same_call(dcall, QST_CALL) || same_call(dcall, NODES_CALL);
        for (int i = 0; i < used; i++)
          if (multi || learned[i][7:0] == 8'h00 || same_call(dcall, learned[i]))
            v.mask[i] = 1'b1;
      end
    end
    frame_verdicts.push_back(v);
  endfunction

  // Clocked side: check results first, then feed the predictor.
  always @(posedge clk) begin
    frame_verdict_t got, want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = '{out_source_channel, out_frame_length, out_forward_mask,
                status_t'(out_status)};
        if (frame_verdicts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: ch=%0d len=%0d mask=%h st=%0d",
                     got.src, got.len, got.mask, got.st);
        end else begin
          want = frame_verdicts.pop_front();
          if (got.src !== want.src || got.len !== want.len ||
              got.mask !== want.mask || got.st !== want.st) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp ch=%0d len=%0d mask=%h st=%0d,",
                       want.src, want.len, want.mask, want.st,
                       " got ch=%0d len=%0d mask=%h st=%0d",
                       got.src, got.len, got.mask, got.st);
          end
        end
      end
      in_taken = in_valid && in_ready;
      if (in_taken) route_byte(int'(in_channel), in_data_byte);
    end
  end

  // Byte driver: advance on acceptance, insert random idle bursts.
  always @(negedge clk) begin
    rx_byte_t nxt;
    if (rst_n && (!in_valid || in_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_bytes.size() == 0) begin
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        send_gap = $urandom_range(0, 10);
        in_valid <= 1'b0;
      end else begin
        nxt = pending_bytes.pop_front();
        in_valid <= 1'b1;
        in_channel <= nxt.ch;
        in_data_byte <= nxt.data;
      end
    end
  end

  // Result sink: stall in random bursts.
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_gap > 0) begin
        hold_gap--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        hold_gap = $urandom_range(0, 10);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic push_byte(input int ch, input logic [7:0] b);
    pending_bytes.push_back('{ch[CH_W-1:0], b});
    bytes_queued++;
  endtask

  function automatic logic [7:0] body_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    return (b == FEND_BYTE) ? 8'hC1 : b;
  endfunction

  // Fill frame_buf with one frame of the given shape, frame end included.
  function automatic void build_frame(input int kind);
    int naddr, nrep, cut, plen;
    logic [55:0] c;
    logic [7:0] b;
    frame_buf.delete();
    if (kind == FK_NOISE) begin
      plen = $urandom_range(1, 6);
      for (int i = 0; i < plen; i++) frame_buf.push_back(8'($urandom_range(0, 255)));
      frame_buf.push_back(FEND_BYTE);
      return;
    end
    b = {4'($urandom_range(0, 15)), 4'h0};
    if (b == FEND_BYTE) b = 8'h00;
    if (kind == FK_NOTDATA) b[3:0] = 4'($urandom_range(1, 15));
    frame_buf.push_back(b);
    if (kind == FK_NOEXT) begin
      naddr = ADDR_MAX;
      nrep = ADDR_MAX - 2;
    end else begin
      naddr = 2 + $urandom_range(0, 8);
      nrep = $urandom_range(0, naddr - 2);
    end
    for (int a = 0; a < naddr; a++) begin
      c = call_pool[$urandom_range(0, 8)];
      if ($urandom_range(0, 4) == 0) c[48 + $urandom_range(1, 4)] ^= 1'b1;
      if ($urandom_range(0, 4) == 0) c[53 +: 2] = 2'($urandom_range(0, 3));
      for (int k = 0; k < ADDR_BYTES - 1; k++) frame_buf.push_back(c[8*k +: 8]);
      b = c[55:48] & 8'h7e;
      if (a == naddr - 1 && kind != FK_NOEXT) b |= EXT_BIT;
      if (a >= 2 && a - 2 < nrep) b |= REPEAT_BIT;
      else if (a < 2 && $urandom_range(0, 1)) b |= REPEAT_BIT;
      if (b == FEND_BYTE) b = REPEAT_BIT;
      frame_buf.push_back(b);
    end
    plen = $urandom_range(0, 12);
    for (int i = 0; i < plen; i++) frame_buf.push_back(body_byte());
    if (kind == FK_TRUNC) begin
      cut = $urandom_range(1, 1 + naddr * ADDR_BYTES - 1);
      while (frame_buf.size() > cut) void'(frame_buf.pop_back());
    end
    frame_buf.push_back(FEND_BYTE);
  endfunction

  task automatic queue_frame(input int ch, input int kind);
    build_frame(kind);
    foreach (frame_buf[i]) push_byte(ch, frame_buf[i]);
  endtask

  // Two frames on different channels, bytes interleaved at random.
  task automatic queue_pair(input int cha, input int chb);
    logic [7:0] qa [$];
    logic [7:0] qb [$];
    build_frame(FK_ROUTED);
    qa = frame_buf;
    build_frame(FK_ROUTED);
    qb = frame_buf;
    while (qa.size() > 0 || qb.size() > 0) begin
      if (qb.size() == 0 || (qa.size() > 0 && $urandom_range(0, 1)))
        push_byte(cha, qa.pop_front());
      else
        push_byte(chb, qb.pop_front());
    end
  endtask

  // Hold until every byte is taken and every verdict has come out.
  task automatic wait_idle();
    while (pending_bytes.size() != 0 || in_valid || frame_verdicts.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (idx == REG_ALL_MULTICAST) multicast_all = val[0];
    else active_chans = int'(val[3:0]);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic run_phase(input bit mc, input int chans, input int nbytes);
    int used, pick, a, b;
    write_reg(REG_ALL_MULTICAST, 32'(mc));
    write_reg(REG_CHANNELS_IN_USE, 32'(chans));
    used = (chans > NUM_CH) ? NUM_CH : chans;
    bytes_queued = 0;
    while (bytes_queued < nbytes) begin
      pick = $urandom_range(0, 19);
      a = $urandom_range(0, used - 1);
      if (pick <= 13) queue_frame(a, FK_ROUTED);
      else if (pick == 14) queue_frame(a, FK_TRUNC);
      else if (pick == 15) queue_frame(a, FK_NOEXT);
      else if (pick == 16) queue_frame(a, FK_NOTDATA);
      else if (pick == 17) queue_frame(a, FK_NOISE);
      else if (pick == 18) begin
        // dropped by the switch; keep it out of the count
        pending_bytes.push_back('{4'($urandom_range(used, 15)), 8'($urandom_range(0, 255))});
      end else if (used > 1) begin
        b = (a + $urandom_range(1, used - 1)) % used;
        queue_pair(a, b);
      end
    end
    wait_idle();
  endtask

  initial begin
    logic [55:0] c;
    foreach (rx_count[i]) begin
      rx_count[i] = 0;
      learned[i] = '0;
    end
    call_pool[0] = QST_CALL;
    call_pool[1] = NODES_CALL;
    call_pool[2] = {8'h60, 48'h40_40_40_40_40_00};   // first byte zero: reads as unlearned
    for (int p = 3; p < 9; p++) begin
      for (int k = 0; k < 6; k++)
        c[8*k +: 8] = ($urandom_range(0, 3) == 0) ? 8'h40 : 8'($urandom_range(8'h41, 8'h5a) << 1);
      c[55:48] = 8'($urandom_range(0, 255)) & 8'h7e;
      call_pool[p] = c;
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset configuration, two channels active.
    push_byte(0, FEND_BYTE);          // lone frame end
    push_byte(1, 8'hFF);              // type byte not data
    push_byte(1, FEND_BYTE);
    push_byte(0, 8'h00);              // header cut short
    push_byte(0, FEND_BYTE);
    push_byte(5, 8'h12);              // inactive channel
    push_byte(15, FEND_BYTE);
    push_byte(1, 8'h00);              // minimal data frame to the broadcast call
    for (int k = 0; k < ADDR_BYTES; k++) push_byte(1, QST_CALL[8*k +: 8]);
    for (int k = 0; k < ADDR_BYTES - 1; k++) push_byte(1, call_pool[3][8*k +: 8]);
    push_byte(1, (call_pool[3][55:48] & 8'h7e) | EXT_BIT);
    push_byte(1, FEND_BYTE);
    wait_idle();

    run_phase(1'b0, 9, 400);
    run_phase(1'b1, 9, 250);
    run_phase(1'b0, 1, 200);
    run_phase(1'b1, 5, 250);
    run_phase(1'b0, 15, 250);
    quiet = 1'b1;
    run_phase(1'b0, 9, 500);

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
rtl/core/afls_pkg.sv
rtl/core/afls_match_unit.sv
rtl/core/ax25_frame_learning_switch.sv
tb/tb_ax25_frame_learning_switch.sv
